@@ sv/sh2_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// SH-2 integer execute package
// Operation codes, widths and the structs shared by the execute unit modules.
// ============================================================================
package sh2_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int MODE_W    = 6;
    localparam int IMM_W     = 8;

    localparam logic [XLEN-1:0] BYTE_MASK = 32'h0000_00FF;
    localparam logic [XLEN-1:0] HALF_MASK = 32'h0000_FFFF;
    localparam int              SHIFT_8   = 8;
    localparam int              SHIFT_16  = 16;
    localparam int              SHIFT_24  = 24;
    localparam int              MSB       = 31;

    typedef enum logic [MODE_W-1:0] {
        OP_ADD     = 6'd0,  OP_ADDI    = 6'd1,  OP_ADDC    = 6'd2,  OP_ADDV    = 6'd3,
        OP_AND     = 6'd4,  OP_ANDI    = 6'd5,  OP_OR      = 6'd6,  OP_ORI     = 6'd7,
        OP_XOR     = 6'd8,  OP_XORI    = 6'd9,  OP_ROTCL   = 6'd10, OP_ROTCR   = 6'd11,
        OP_ROTL    = 6'd12, OP_ROTR    = 6'd13, OP_SHAL    = 6'd14, OP_SHAR    = 6'd15,
        OP_SHLL2   = 6'd16, OP_SHLL8   = 6'd17, OP_SHLL16  = 6'd18, OP_SHLR    = 6'd19,
        OP_SHLR2   = 6'd20, OP_SHLR8   = 6'd21, OP_SHLR16  = 6'd22, OP_NOT     = 6'd23,
        OP_NEG     = 6'd24, OP_DT      = 6'd25, OP_EXTSB   = 6'd26, OP_EXTSW   = 6'd27,
        OP_EXTUB   = 6'd28, OP_EXTUW   = 6'd29, OP_DIV0S   = 6'd30, OP_DIV0U   = 6'd31,
        OP_CLRT    = 6'd32, OP_SETT    = 6'd33, OP_CMPEQ   = 6'd34, OP_CMPGE   = 6'd35,
        OP_CMPGT   = 6'd36, OP_CMPHI   = 6'd37, OP_CMPHS   = 6'd38, OP_CMPPL   = 6'd39,
        OP_CMPPZ   = 6'd40, OP_CMPSTR  = 6'd41, OP_CMPEQI  = 6'd42, OP_MOV    = 6'd43,
        OP_MOVI    = 6'd44, OP_MOVT    = 6'd45
    } t_op;

    typedef struct packed {
        logic t;
        logic q;
        logic m;
    } t_flags;

    // Decoded item held in front of the ALU.
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [REG_IDX_W-1:0] dst_index;
        logic [IMM_W-1:0]     immediate;
    } t_alu_ctl;

    typedef struct packed {
        logic [XLEN-1:0]      value;
        logic                 wrote;
        logic [REG_IDX_W-1:0] index;
        t_flags               flags;
    } t_alu_res;

    // The immediate forms of the logic ops and CMP/EQ #imm use R0 as the first operand.
    function automatic logic uses_r0(input logic [MODE_W-1:0] mode);
        logic r;
        case (mode) inside
            OP_ANDI, OP_ORI, OP_XORI, OP_CMPEQI: r = 1'b1;
            default:                             r = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/sh2_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// SH-2 execute channels
// Valid/ready request channel into the unit and result channel out of it.
// ============================================================================
interface sh2_req_if import sh2_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [REG_IDX_W-1:0] dst_index;
    logic [REG_IDX_W-1:0] src_index;
    logic [IMM_W-1:0]     immediate;

    modport source (output valid, mode, dst_index, src_index, immediate, input ready);
    modport sink   (input valid, mode, dst_index, src_index, immediate, output ready);
endinterface

interface sh2_rsp_if import sh2_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [XLEN-1:0]      result_value;
    logic                 wrote_register;
    logic [REG_IDX_W-1:0] written_index;
    logic                 t_flag;
    logic                 q_flag;
    logic                 m_flag;

    modport source (output valid, result_value, wrote_register, written_index,
                    t_flag, q_flag, m_flag, input ready);
    modport sink   (input valid, result_value, wrote_register, written_index,
                    t_flag, q_flag, m_flag, output ready);
endinterface
`default_nettype wire

@@ sv/sh2_integer_execute_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// SH-2 integer execute unit
// Executes one decoded register instruction per request against R0..R15, T, Q, M.
// ============================================================================
// Usage:
//   Requests arrive on i_req (mode, dst_index, src_index, immediate) under a
//   valid/ready handshake. Each request yields exactly one result on o_rsp:
//   the value written (zero if none), the write flag, the register index and
//   the T, Q and M bits after the instruction.
// Pipeline and throughput:
//   A request accepted at one clock edge is held in the ALU stage, and its
//   result is registered into the output stage that drives o_rsp; one
//   request per cycle is taken while the receiver keeps up. The register file
//   is read at the accepting edge and the ALU result and write-back are
//   registered when the ALU stage advances; a same-edge bypass covers the read
//   of a register that the previous instruction is writing.
// Reset:
//   i_rst_n is synchronous and active low. It empties the pipeline, clears
//   T, Q and M and marks all sixteen registers invalid, so they read as zero
//   until written. No clearing pass is needed.
// Stalls:
//   When o_rsp is held, the instruction in the ALU stage waits with its
//   operands and i_req.ready drops once both stages are full.
// ============================================================================
module sh2_integer_execute_unit import sh2_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sh2_req_if.sink    i_req,
    sh2_rsp_if.source  o_rsp
);

    // Pipeline control.
    logic                 r_s1_valid;
    logic                 r_out_valid;
    logic                 w_accept;
    logic                 w_adv;

    // ALU stage payload.
    t_alu_ctl             r_s1_ctl;
    logic [REG_IDX_W-1:0] r_s1_ra;
    logic [REG_IDX_W-1:0] r_s1_rb;
    logic                 r_s1_va;
    logic                 r_s1_vb;

    // Register file state.
    logic [REG_COUNT-1:0] r_vld;
    t_flags               r_flags;
    logic [REG_IDX_W-1:0] w_raddr_a;
    logic [XLEN-1:0]      w_ram_a;
    logic [XLEN-1:0]      w_ram_b;

    // Write that happened at the edge the ALU-stage request was read.
    logic                 r_byp_vld;
    logic [REG_IDX_W-1:0] r_byp_idx;
    logic [XLEN-1:0]      r_byp_val;

    logic [XLEN-1:0]      w_rn;
    logic [XLEN-1:0]      w_rm;
    t_alu_res             w_res;
    t_alu_res             r_out;
    logic                 w_wr_en;

    assign w_adv    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign w_accept = i_req.valid && i_req.ready;
    assign w_wr_en  = w_adv && w_res.wrote;

    assign i_req.ready = !r_s1_valid || w_adv;

    // The immediate logic ops and CMP/EQ #imm read R0 through the first port.
    assign w_raddr_a = uses_r0(i_req.mode) ? '0 : i_req.dst_index;

    sh2_ram #(
        .WIDTH (XLEN),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (w_wr_en),
        .i_waddr   (w_res.index),
        .i_wdata   (w_res.value),
        .i_re      (w_accept),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (i_req.src_index),
        .o_rdata_a (w_ram_a),
        .o_rdata_b (w_ram_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_flags     <= '0;
            r_byp_vld   <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= w_res.flags;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_vld[w_res.index] <= 1'b1;
            end
            if (w_accept) begin
                r_byp_vld <= w_wr_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ctl.mode      <= i_req.mode;
            r_s1_ctl.dst_index <= i_req.dst_index;
            r_s1_ctl.immediate <= i_req.immediate;
            r_s1_ra            <= w_raddr_a;
            r_s1_rb            <= i_req.src_index;
            r_s1_va            <= r_vld[w_raddr_a];
            r_s1_vb            <= r_vld[i_req.src_index];
            r_byp_idx          <= w_res.index;
            r_byp_val          <= w_res.value;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // The RAM returns old data for a register written at the read edge, and a
    // register never written reads as zero.
    always_comb begin
        if (r_byp_vld && (r_byp_idx == r_s1_ra)) begin
            w_rn = r_byp_val;
        end else begin
            w_rn = r_s1_va ? w_ram_a : '0;
        end
        if (r_byp_vld && (r_byp_idx == r_s1_rb)) begin
            w_rm = r_byp_val;
        end else begin
            w_rm = r_s1_vb ? w_ram_b : '0;
        end
    end

    sh2_alu u_alu (
        .i_ctl   (r_s1_ctl),
        .i_rn    (w_rn),
        .i_rm    (w_rm),
        .i_flags (r_flags),
        .o_res   (w_res)
    );

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_value   = r_out.value;
    assign o_rsp.wrote_register = r_out.wrote;
    assign o_rsp.written_index  = r_out.index;
    assign o_rsp.t_flag         = r_out.flags.t;
    assign o_rsp.q_flag         = r_out.flags.q;
    assign o_rsp.m_flag         = r_out.flags.m;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid && !r_s1_valid)
        else $error("pipeline not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_s1_ctl))
        else $error("stalled instruction lost or changed");

    a_write_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_vld[$past(w_res.index)])
        else $error("written register not marked valid");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.wrote_register |->
            o_rsp.result_value == '0 && o_rsp.written_index == '0)
        else $error("result fields nonzero without a register write");
`endif

endmodule
`default_nettype wire

@@ sv/sh2_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Generic RAM
// One write port and two read ports with registered read data.
// ============================================================================
module sh2_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the contents before a write at the same edge.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

@@ sv/sh2_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// SH-2 ALU
// Computes the register result and the new T, Q and M bits of one instruction.
// ============================================================================
module sh2_alu import sh2_pkg::*; (
    input  wire t_alu_ctl        i_ctl,
    input  wire logic [XLEN-1:0] i_rn,
    input  wire logic [XLEN-1:0] i_rm,
    input  wire t_flags          i_flags,
    output t_alu_res             o_res
);

    logic [XLEN-1:0] w_simm;
    logic [XLEN-1:0] w_zimm;
    logic [XLEN:0]   w_addc;
    logic [XLEN-1:0] w_sum;
    logic [XLEN-1:0] w_dec;
    logic [XLEN-1:0] w_diff;
    logic            w_wr;
    logic [XLEN-1:0] w_val;
    t_flags          w_fl;

    assign w_simm = {{(XLEN-IMM_W){i_ctl.immediate[IMM_W-1]}}, i_ctl.immediate};
    assign w_zimm = {{(XLEN-IMM_W){1'b0}}, i_ctl.immediate};
    assign w_sum  = i_rn + i_rm;
    assign w_addc = {1'b0, i_rn} + {1'b0, i_rm} + {{XLEN{1'b0}}, i_flags.t};
    assign w_dec  = i_rn - {{(XLEN-1){1'b0}}, 1'b1};
    assign w_diff = i_rn ^ i_rm;

    always_comb begin
        w_wr  = 1'b1;
        w_val = '0;
        w_fl  = i_flags;
        unique case (i_ctl.mode)
            OP_ADD:    w_val = w_sum;
            OP_ADDI:   w_val = i_rn + w_simm;
            OP_ADDC: begin
                w_val  = w_addc[XLEN-1:0];
                w_fl.t = w_addc[XLEN];
            end
            OP_ADDV: begin
                w_val  = w_sum;
                w_fl.t = (i_rn[MSB] ^ w_sum[MSB]) & (i_rm[MSB] ^ w_sum[MSB]);
            end
            OP_AND:    w_val = i_rn & i_rm;
            OP_ANDI:   w_val = i_rn & w_zimm;
            OP_OR:     w_val = i_rn | i_rm;
            OP_ORI:    w_val = i_rn | w_zimm;
            OP_XOR:    w_val = i_rn ^ i_rm;
            OP_XORI:   w_val = i_rn ^ w_zimm;
            OP_ROTCL: begin
                w_val  = {i_rn[XLEN-2:0], i_flags.t};
                w_fl.t = i_rn[MSB];
            end
            OP_ROTCR: begin
                w_val  = {i_flags.t, i_rn[XLEN-1:1]};
                w_fl.t = i_rn[0];
            end
            OP_ROTL: begin
                w_val  = {i_rn[XLEN-2:0], i_rn[MSB]};
                w_fl.t = i_rn[MSB];
            end
            OP_ROTR: begin
                w_val  = {i_rn[0], i_rn[XLEN-1:1]};
                w_fl.t = i_rn[0];
            end
            OP_SHAL: begin
                w_val  = {i_rn[XLEN-2:0], 1'b0};
                w_fl.t = i_rn[MSB];
            end
            OP_SHAR: begin
                w_val  = {i_rn[MSB], i_rn[XLEN-1:1]};
                w_fl.t = i_rn[0];
            end
            OP_SHLL2:  w_val = i_rn << 2;
            OP_SHLL8:  w_val = i_rn << SHIFT_8;
            OP_SHLL16: w_val = i_rn << SHIFT_16;
            OP_SHLR: begin
                w_val  = {1'b0, i_rn[XLEN-1:1]};
                w_fl.t = i_rn[0];
            end
            OP_SHLR2:  w_val = i_rn >> 2;
            OP_SHLR8:  w_val = i_rn >> SHIFT_8;
            OP_SHLR16: w_val = i_rn >> SHIFT_16;
            OP_NOT:    w_val = ~i_rm;
            OP_NEG:    w_val = '0 - i_rm;
            OP_DT: begin
                w_val  = w_dec;
                w_fl.t = (w_dec == '0);
            end
            OP_EXTSB:  w_val = {{(XLEN-8){i_rm[7]}}, i_rm[7:0]};
            OP_EXTSW:  w_val = {{(XLEN-16){i_rm[15]}}, i_rm[15:0]};
            OP_EXTUB:  w_val = i_rm & BYTE_MASK;
            OP_EXTUW:  w_val = i_rm & HALF_MASK;
            OP_DIV0S: begin
                w_wr   = 1'b0;
                w_fl.q = i_rn[MSB];
                w_fl.m = i_rm[MSB];
                w_fl.t = i_rn[MSB] ^ i_rm[MSB];
            end
            OP_DIV0U: begin
                w_wr = 1'b0;
                w_fl = '0;
            end
            OP_CLRT: begin
                w_wr   = 1'b0;
                w_fl.t = 1'b0;
            end
            OP_SETT: begin
                w_wr   = 1'b0;
                w_fl.t = 1'b1;
            end
            OP_CMPEQ: begin
                w_wr   = 1'b0;
                w_fl.t = (i_rn == i_rm);
            end
            OP_CMPGE: begin
                w_wr   = 1'b0;
                w_fl.t = ($signed(i_rn) >= $signed(i_rm));
            end
            OP_CMPGT: begin
                w_wr   = 1'b0;
                w_fl.t = ($signed(i_rn) > $signed(i_rm));
            end
            OP_CMPHI: begin
                w_wr   = 1'b0;
                w_fl.t = (i_rn > i_rm);
            end
            OP_CMPHS: begin
                w_wr   = 1'b0;
                w_fl.t = (i_rn >= i_rm);
            end
            OP_CMPPL: begin
                w_wr   = 1'b0;
                w_fl.t = !i_rn[MSB] && (i_rn != '0);
            end
            OP_CMPPZ: begin
                w_wr   = 1'b0;
                w_fl.t = !i_rn[MSB];
            end
            OP_CMPSTR: begin
                // T is set when any byte lane of the two operands matches.
                w_wr   = 1'b0;
                w_fl.t = (w_diff[7:0] == '0) || (w_diff[15:8] == '0) ||
                         (w_diff[23:16] == '0) || (w_diff[MSB:SHIFT_24] == '0);
            end
            OP_CMPEQI: begin
                w_wr   = 1'b0;
                w_fl.t = (i_rn == w_simm);
            end
            OP_MOV:    w_val = i_rm;
            OP_MOVI:   w_val = w_simm;
            OP_MOVT:   w_val = {{(XLEN-1){1'b0}}, i_flags.t};
            default:   w_wr  = 1'b0;
        endcase
    end

    always_comb begin
        o_res.wrote = w_wr;
        o_res.flags = w_fl;
        o_res.value = w_wr ? w_val : '0;
        if (!w_wr) begin
            o_res.index = '0;
        end else if (uses_r0(i_ctl.mode)) begin
            o_res.index = '0;
        end else begin
            o_res.index = i_ctl.dst_index;
        end
    end

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// SH-2 integer execute unit testbench
// Drives decoded register instructions into the unit over the request channel
// and checks every result against an in-bench model of the architectural
// state (R0..R15, T, Q, M). A directed part covers the carry, overflow,
// string-compare, divide-setup and unused-code cases. It is followed by an
// opcode sweep and long runs of random instructions under three idling
// profiles on the two channels.
// ============================================================================
module testbench import sh2_pkg::*; ();

    // Highest value the mode field can carry; codes above OP_MOVT do nothing.
    localparam logic [MODE_W-1:0] OP_UNUSED_LAST = 6'd63;
    localparam int                CLK_HALF_NS    = 4;
    localparam int                RESET_CYCLES   = 10;
    localparam int                DRAIN_CYCLES   = 8;
    localparam int                REPORT_LIMIT   = 10;
    localparam int                RANDOM_PER_PHASE = 395;

    bit   clk;
    logic rst_n;

    sh2_req_if req_ch ();
    sh2_rsp_if rsp_ch ();

    sh2_integer_execute_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Architectural state as the instruction stream should leave it.
    logic [XLEN-1:0] arch_regs [REG_COUNT];
    logic            arch_t;
    logic            arch_q;
    logic            arch_m;

    // Results still owed by the unit, oldest first.
    t_alu_res pending_writebacks [$];

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;

    initial begin
        forever #CLK_HALF_NS clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Instruction model. Executes one instruction on the architectural state
    // and returns the result the unit must report for it. A code that writes
    // no register reports zero for both the value and the index.
    // ------------------------------------------------------------------------
    function automatic t_alu_res execute_instruction(
        input logic [MODE_W-1:0]    op,
        input logic [REG_IDX_W-1:0] rn_idx,
        input logic [REG_IDX_W-1:0] rm_idx,
        input logic [IMM_W-1:0]     imm
    );
        logic [XLEN-1:0]      rn;
        logic [XLEN-1:0]      rm;
        logic [XLEN-1:0]      r0;
        logic [XLEN-1:0]      simm;
        logic [XLEN-1:0]      zimm;
        logic [XLEN-1:0]      res;
        logic [XLEN-1:0]      diff;
        logic [XLEN:0]        wide_sum;
        logic                 wr;
        logic [REG_IDX_W-1:0] widx;
        t_alu_res             res_item;

        rn   = arch_regs[rn_idx];
        rm   = arch_regs[rm_idx];
        r0   = arch_regs[0];
        simm = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
        zimm = {{(XLEN-IMM_W){1'b0}}, imm};
        res  = '0;
        wr   = 1'b1;
        widx = rn_idx;

        case (op)
            OP_ADD:    res = rn + rm;
            OP_ADDI:   res = rn + simm;
            OP_ADDC: begin
                // T is the carry out of Rn + Rm + T.
                wide_sum = {1'b0, rn} + {1'b0, rm} + {{XLEN{1'b0}}, arch_t};
                res      = wide_sum[XLEN-1:0];
                arch_t   = wide_sum[XLEN];
            end
            OP_ADDV: begin
                // Signed overflow: both operands differ in sign from the sum.
                res    = rn + rm;
                diff   = (rn ^ res) & (rm ^ res);
                arch_t = diff[MSB];
            end
            OP_AND:    res = rn & rm;
            OP_ANDI: begin
                res  = r0 & zimm;
                widx = '0;
            end
            OP_OR:     res = rn | rm;
            OP_ORI: begin
                res  = r0 | zimm;
                widx = '0;
            end
            OP_XOR:    res = rn ^ rm;
            OP_XORI: begin
                res  = r0 ^ zimm;
                widx = '0;
            end
            OP_ROTCL: begin
                res    = {rn[XLEN-2:0], arch_t};
                arch_t = rn[MSB];
            end
            OP_ROTCR: begin
                res    = {arch_t, rn[XLEN-1:1]};
                arch_t = rn[0];
            end
            OP_ROTL: begin
                res    = {rn[XLEN-2:0], rn[MSB]};
                arch_t = rn[MSB];
            end
            OP_ROTR: begin
                res    = {rn[0], rn[XLEN-1:1]};
                arch_t = rn[0];
            end
            OP_SHAL: begin
                res    = rn << 1;
                arch_t = rn[MSB];
            end
            OP_SHAR: begin
                res    = {rn[MSB], rn[XLEN-1:1]};
                arch_t = rn[0];
            end
            OP_SHLL2:  res = rn << 2;
            OP_SHLL8:  res = rn << SHIFT_8;
            OP_SHLL16: res = rn << SHIFT_16;
            OP_SHLR: begin
                res    = rn >> 1;
                arch_t = rn[0];
            end
            OP_SHLR2:  res = rn >> 2;
            OP_SHLR8:  res = rn >> SHIFT_8;
            OP_SHLR16: res = rn >> SHIFT_16;
            OP_NOT:    res = ~rm;
            OP_NEG:    res = '0 - rm;
            OP_DT: begin
                res    = rn - 1;
                arch_t = (res == '0);
            end
            OP_EXTSB:  res = {{(XLEN-8){rm[7]}}, rm[7:0]};
            OP_EXTSW:  res = {{(XLEN-16){rm[15]}}, rm[15:0]};
            OP_EXTUB:  res = rm & BYTE_MASK;
            OP_EXTUW:  res = rm & HALF_MASK;
            OP_DIV0S: begin
                wr     = 1'b0;
                arch_q = rn[MSB];
                arch_m = rm[MSB];
                arch_t = rn[MSB] ^ rm[MSB];
            end
            OP_DIV0U: begin
                wr     = 1'b0;
                arch_t = 1'b0;
                arch_q = 1'b0;
                arch_m = 1'b0;
            end
            OP_CLRT: begin
                wr     = 1'b0;
                arch_t = 1'b0;
            end
            OP_SETT: begin
                wr     = 1'b0;
                arch_t = 1'b1;
            end
            OP_CMPEQ: begin
                wr     = 1'b0;
                arch_t = (rn == rm);
            end
            OP_CMPGE: begin
                wr     = 1'b0;
                arch_t = ($signed(rn) >= $signed(rm));
            end
            OP_CMPGT: begin
                wr     = 1'b0;
                arch_t = ($signed(rn) > $signed(rm));
            end
            OP_CMPHI: begin
                wr     = 1'b0;
                arch_t = (rn > rm);
            end
            OP_CMPHS: begin
                wr     = 1'b0;
                arch_t = (rn >= rm);
            end
            OP_CMPPL: begin
                wr     = 1'b0;
                arch_t = ($signed(rn) > 32'sd0);
            end
            OP_CMPPZ: begin
                wr     = 1'b0;
                arch_t = ~rn[MSB];
            end
            OP_CMPSTR: begin
                // T is set when any byte lane of Rn matches the same lane of Rm.
                wr     = 1'b0;
                diff   = rn ^ rm;
                arch_t = (diff[7:0] == 8'h00) || (diff[15:8] == 8'h00) ||
                         (diff[23:16] == 8'h00) || (diff[31:24] == 8'h00);
            end
            OP_CMPEQI: begin
                wr     = 1'b0;
                arch_t = (r0 == simm);
            end
            OP_MOV:    res = rm;
            OP_MOVI:   res = simm;
            OP_MOVT:   res = {{(XLEN-1){1'b0}}, arch_t};
            default:   wr = 1'b0;
        endcase

        if (wr) begin
            arch_regs[widx] = res;
        end else begin
            res  = '0;
            widx = '0;
        end

        res_item.value   = res;
        res_item.wrote   = wr;
        res_item.index   = widx;
        res_item.flags.t = arch_t;
        res_item.flags.q = arch_q;
        res_item.flags.m = arch_m;
        return res_item;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. Fields change at the falling edge; the request counts as
    // taken at the first rising edge where ready is seen high, and only then
    // is the model advanced. Valid is left high on return so back-to-back
    // requests keep it asserted without a dip.
    // ------------------------------------------------------------------------
    task automatic send_request(
        input logic [MODE_W-1:0]    op,
        input logic [REG_IDX_W-1:0] rn_idx,
        input logic [REG_IDX_W-1:0] rm_idx,
        input logic [IMM_W-1:0]     imm
    );
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= op;
        req_ch.dst_index <= rn_idx;
        req_ch.src_index <= rm_idx;
        req_ch.immediate <= imm;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        pending_writebacks.push_back(execute_instruction(op, rn_idx, rm_idx, imm));
    endtask

    // Stops issuing and waits for the unit to hand back every owed result.
    task automatic wait_for_writebacks();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_writebacks.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker. Each result taken on the output channel is matched with
    // the oldest owed result, field by field. A result that arrives when none
    // is owed is a failure as well.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_writeback
        t_alu_res want;
        t_alu_res got;

        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.value   = rsp_ch.result_value;
            got.wrote   = rsp_ch.wrote_register;
            got.index   = rsp_ch.written_index;
            got.flags.t = rsp_ch.t_flag;
            got.flags.q = rsp_ch.q_flag;
            got.flags.m = rsp_ch.m_flag;
            if (pending_writebacks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no request outstanding:", $realtime);
                    $display("%0t:          actual   value=%h wr=%b idx=%0d t=%b q=%b m=%b",
                             $realtime, got.value, got.wrote, got.index,
                             got.flags.t, got.flags.q, got.flags.m);
                end
            end else begin
                want = pending_writebacks.pop_front();
                if (got.value !== want.value || got.wrote !== want.wrote ||
                    got.index !== want.index || got.flags.t !== want.flags.t ||
                    got.flags.q !== want.flags.q || got.flags.m !== want.flags.m) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch expected value=%h wr=%b idx=%0d t=%b q=%b m=%b",
                                 $realtime, want.value, want.wrote, want.index,
                                 want.flags.t, want.flags.q, want.flags.m);
                        $display("%0t:          actual   value=%h wr=%b idx=%0d t=%b q=%b m=%b",
                                 $realtime, got.value, got.wrote, got.index,
                                 got.flags.t, got.flags.q, got.flags.m);
                    end
                end
            end
        end
    end

    // The result side stalls at random according to the current profile.
    always @(negedge clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Carry out of ADDC with T feeding in, and ADDV signed overflow both ways.
    task automatic test_carry_and_overflow();
        send_request(OP_MOVI,  4'd1,  4'd0, 8'hFF);   // R1 = all ones
        send_request(OP_MOVI,  4'd15, 4'd0, 8'h7F);   // R15 = largest positive imm
        send_request(OP_MOV,   4'd2,  4'd1, 8'h00);
        send_request(OP_SETT,  4'd0,  4'd0, 8'h00);
        send_request(OP_ADDC,  4'd2,  4'd15, 8'h00);  // wraps, carry out set
        send_request(OP_ADDC,  4'd2,  4'd0, 8'h00);   // carry in only, no carry out
        send_request(OP_SHLR,  4'd1,  4'd0, 8'h00);   // R1 = 0x7FFF_FFFF
        send_request(OP_MOVI,  4'd3,  4'd0, 8'h01);
        send_request(OP_ADDV,  4'd1,  4'd3, 8'h00);   // positive overflow
        send_request(OP_MOV,   4'd4,  4'd1, 8'h00);
        send_request(OP_ADDV,  4'd4,  4'd4, 8'h00);   // negative overflow to zero
        send_request(OP_ADDV,  4'd3,  4'd3, 8'h00);   // no overflow
    endtask

    // Divide set-ups, string compare, compare with immediate and an unused code.
    task automatic test_status_bit_ops();
        send_request(OP_DIV0S,  4'd1,  4'd3,  8'h00); // Rn negative: Q=1, M=0
        send_request(OP_DIV0S,  4'd3,  4'd1,  8'h00); // Rm negative: Q=0, M=1
        send_request(OP_DIV0U,  4'd0,  4'd0,  8'h00);
        send_request(OP_MOVI,   4'd6,  4'd0,  8'hFF);
        send_request(OP_CMPSTR, 4'd6,  4'd0,  8'h00); // no byte lane matches
        send_request(OP_CMPSTR, 4'd1,  4'd3,  8'h00); // middle lanes match
        send_request(OP_CMPEQI, 4'd0,  4'd0,  8'h00);
        send_request(OP_CMPEQI, 4'd0,  4'd15, 8'h80); // most negative immediate
        send_request(OP_XORI,   4'd0,  4'd0,  8'hFF); // immediate is zero-extended
        send_request(OP_MOVT,   4'd15, 4'd0,  8'h00);
        send_request(OP_UNUSED_LAST, 4'd15, 4'd15, 8'hFF);
        send_request(OP_DT,     4'd3,  4'd0,  8'h00); // counts down from two to one
    endtask

    // Walks through every mode code once, unused ones included.
    task automatic test_every_opcode();
        for (int code = 0; code <= int'(OP_UNUSED_LAST); code++) begin
            send_request(MODE_W'(code), REG_IDX_W'($urandom_range(15)),
                         REG_IDX_W'($urandom_range(15)), IMM_W'($urandom_range(255)));
        end
    endtask

    // Random instruction stream. Rm often equals Rn so that the equality and
    // byte-lane compares see true outcomes; a tenth of the requests carry an
    // unused code, and those are not counted.
    task automatic test_random_instructions(input int count);
        int                   issued;
        logic [MODE_W-1:0]    op;
        logic [REG_IDX_W-1:0] rn_idx;
        logic [REG_IDX_W-1:0] rm_idx;

        issued = 0;
        while (issued < count) begin
            if ($urandom_range(9) == 0) begin
                op = MODE_W'($urandom_range(int'(OP_UNUSED_LAST), int'(OP_MOVT) + 1));
            end else begin
                op = MODE_W'($urandom_range(int'(OP_MOVT)));
                issued++;
            end
            rn_idx = REG_IDX_W'($urandom_range(15));
            rm_idx = ($urandom_range(3) == 0) ? rn_idx : REG_IDX_W'($urandom_range(15));
            send_request(op, rn_idx, rm_idx, IMM_W'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset, directed tests, then three random phases with the
    // idling moved from the result side to the request side and then off.
    // The unit is drained between phases, which also exercises a full stop
    // of the request stream.
    // ------------------------------------------------------------------------
    initial begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = '0;
        req_ch.dst_index = '0;
        req_ch.src_index = '0;
        req_ch.immediate = '0;
        mismatch_count   = 0;
        send_idle_pct    = 10;
        recv_idle_pct    = 84;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        arch_t = 1'b0;
        arch_q = 1'b0;
        arch_m = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_carry_and_overflow();
        test_status_bit_ops();
        wait_for_writebacks();
        test_every_opcode();
        test_random_instructions(RANDOM_PER_PHASE);
        wait_for_writebacks();

        send_idle_pct = 84;
        recv_idle_pct = 10;
        test_random_instructions(RANDOM_PER_PHASE);
        wait_for_writebacks();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_instructions(RANDOM_PER_PHASE);
        wait_for_writebacks();

        // Run on so that any stray result would still be caught.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
